@@ hdl/rnps_pkg.sv @@
// shared types, constants and register defaults for the radio node power search block
package rnps_pkg;

   localparam int unsigned NODE_COUNT_DEFAULT = 16;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned NODE_W   = 4;
   localparam int unsigned RSSI_W   = 9;
   localparam int unsigned POWER_W  = 4;
   localparam int unsigned WAIT_W   = 16;
   localparam int unsigned ADDR_W   = 8;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 16;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START_SEARCH = 2'd0,
      OP_START_PING   = 2'd1,
      OP_TICK         = 2'd2,
      OP_REPLY        = 2'd3
   } opcode_type;

   typedef enum logic {
      EV_TRANSMIT = 1'b0,
      EV_FINISHED = 1'b1
   } event_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DESIRED_RSSI = 3'd0,
      CSR_LOWEST_POWER = 3'd1,
      CSR_HIGHEST_POWER = 3'd2,
      CSR_REPLY_WAIT   = 3'd3,
      CSR_ADDR_OFFSET  = 3'd4
   } csr_index_type;

   localparam logic signed [RSSI_W-1:0] DESIRED_RSSI_RESET = -9'sd70;
   localparam logic [POWER_W-1:0]       LOWEST_POWER_RESET = 4'd0;
   localparam logic [POWER_W-1:0]       HIGHEST_POWER_RESET = 4'd11;
   localparam logic [WAIT_W-1:0]        REPLY_WAIT_RESET = 16'd100;
   localparam logic [ADDR_W-1:0]        ADDR_OFFSET_RESET = 8'd100;

   typedef struct packed {
      event_type            event_res;
      logic [ADDR_W-1:0]    node_address;
      logic [POWER_W-1:0]   power_level;
      logic                 node_online;
   } rsp_type;

endpackage

@@ hdl/radio_node_power_search_top.sv @@
// radio node power search: poll controller with per-node power tracking and online reports
//
// request channel (req_*): one beat per event; req_tuser carries the opcode
// (start search, start ping, tick, reply) and req_tdata the node index and reply fields.
// response channel (rsp_*): transmit commands and poll-finished reports, at most one
// per request beat, registered in the output stage or, while it stalls, the skid stage.
// configuration (csr_*): single-cycle register writes, which the user makes only while
// the block is idle; the block does not enforce this. throughput: one request beat per
// cycle while req_tready is high. the per-node power table is a one-port memory with
// registered read; a ping start fetches the stored power into the current-node register
// over the following cycle without stalling the request side. an output register plus
// one skid stage decouple the two sides: requests keep flowing while a response waits,
// and req_tready drops only when both hold a beat. reset: synchronous, active high;
// clears the poll state, the response stages, the configuration registers to defaults and
// the per-node valid bits, so every node reads as power zero; no clearing pass is needed.
module radio_node_power_search_top #(
   parameter int unsigned NODE_COUNT = rnps_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // node_index[3:0], reply_rssi_dbm[12:4], reply_power[16:13], zero fill
   input  logic [rnps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[1:0]
   input  logic [rnps_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // node_address[7:0], power_level[11:8], node_online[12], zero fill
   output logic [rnps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // event_res[0]
   output logic                               rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [rnps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rnps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned PW = rnps_pkg::POWER_W;
   localparam int unsigned WW = rnps_pkg::WAIT_W;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_PING   = 2'd2
   } mode_type;

   // configuration
   logic signed [rnps_pkg::RSSI_W-1:0] desired_ff;
   logic [PW-1:0]                      lowest_ff;
   logic [PW-1:0]                      highest_ff;
   logic [WW-1:0]                      wait_ticks_ff;
   logic [rnps_pkg::ADDR_W-1:0]        offset_ff;

   // poll state
   mode_type             mode_ff, mode_in;
   logic                 waiting_ff, waiting_in;
   logic [rnps_pkg::NODE_W-1:0] cur_node_ff, cur_node_in;
   logic [WW-1:0]        wait_cnt_ff, wait_cnt_in;
   logic [PW-1:0]        cur_power_ff, cur_power_in;
   logic                 cur_answered_ff, cur_answered_in;
   logic                 pending_ff, pending_in;
   logic [PW-1:0]        rd_data_ff;
   logic                 rd_valid_ff;
   logic [NODE_COUNT-1:0] valid_ff;

   // power table
   logic [PW-1:0]        power_mem [NODE_COUNT];
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [PW-1:0]        wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;

   // response stages
   logic                 out_valid_ff, out_valid_in;
   rnps_pkg::rsp_type    out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   rnps_pkg::rsp_type    skid_ff, skid_in;

   // request fields
   rnps_pkg::opcode_type         op;
   logic [rnps_pkg::NODE_W-1:0]  req_node;
   logic [rnps_pkg::RSSI_W-1:0]  req_rssi;
   logic [PW-1:0]                req_power;
   logic                         accept;
   logic                         idx_ok;

   // datapath
   logic [PW-1:0]        eff_power;
   logic signed [9:0]    rssi_diff;
   logic signed [9:0]    rssi_adj;
   logic signed [9:0]    rssi_quot;
   logic signed [10:0]   reply_sum;
   logic [PW-1:0]        reply_level;
   logic [WW-1:0]        cnt_inc;
   logic                 elapsed;
   logic                 res_valid;
   rnps_pkg::rsp_type    res;

   assign op        = rnps_pkg::opcode_type'(req_tuser);
   assign req_node  = req_tdata[3:0];
   assign req_rssi  = req_tdata[12:4];
   assign req_power = req_tdata[16:13];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign idx_ok     = {1'b0, 8'(req_node)} < 9'(NODE_COUNT);

   assign eff_power = pending_ff ? (rd_valid_ff ? rd_data_ff : '0) : cur_power_ff;

   // reply power: reply_power + (desired - rssi)/4 toward zero, clamped
   assign rssi_diff = $signed({desired_ff[rnps_pkg::RSSI_W-1], desired_ff})
                    - $signed({req_rssi[rnps_pkg::RSSI_W-1], req_rssi});
   assign rssi_adj  = rssi_diff + $signed({8'b0, rssi_diff[9], rssi_diff[9]});
   assign rssi_quot = rssi_adj >>> 2;
   assign reply_sum = $signed({7'b0, req_power}) + $signed({rssi_quot[9], rssi_quot});

   always_comb begin
      if (reply_sum > $signed({7'b0, highest_ff})) begin
         reply_level = highest_ff;
      end else if (reply_sum < $signed({7'b0, lowest_ff})) begin
         reply_level = lowest_ff;
      end else begin
         reply_level = reply_sum[PW-1:0];
      end
   end

   assign cnt_inc = (wait_cnt_ff == '1) ? wait_cnt_ff : wait_cnt_ff + 1'b1;
   assign elapsed = cnt_inc >= wait_ticks_ff;

   always_comb begin
      mode_in         = mode_ff;
      waiting_in      = waiting_ff;
      cur_node_in     = cur_node_ff;
      wait_cnt_in     = wait_cnt_ff;
      cur_power_in    = eff_power;
      cur_answered_in = cur_answered_ff;
      pending_in      = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = IDX_W'(cur_node_ff);
      wr_data         = eff_power;
      rd_en           = 1'b0;
      rd_addr         = IDX_W'(req_node);
      res_valid       = 1'b0;
      res.event_res   = rnps_pkg::EV_TRANSMIT;
      res.node_address = rnps_pkg::ADDR_W'(cur_node_ff) + offset_ff;
      res.power_level = eff_power;
      res.node_online = 1'b0;
      if (accept) begin
         case (op)
            rnps_pkg::OP_START_SEARCH, rnps_pkg::OP_START_PING: begin
               if (idx_ok) begin
                  cur_node_in     = req_node;
                  cur_answered_in = 1'b0;
                  waiting_in      = 1'b0;
                  if (op == rnps_pkg::OP_START_SEARCH) begin
                     mode_in      = MODE_SEARCH;
                     cur_power_in = lowest_ff;
                     wr_en        = 1'b1;
                     wr_addr      = IDX_W'(req_node);
                     wr_data      = lowest_ff;
                  end else begin
                     mode_in    = MODE_PING;
                     rd_en      = 1'b1;
                     pending_in = 1'b1;
                  end
               end else begin
                  pending_in = pending_ff;
               end
            end
            rnps_pkg::OP_REPLY: begin
               cur_power_in    = reply_level;
               cur_answered_in = 1'b1;
               wr_en           = 1'b1;
               wr_data         = reply_level;
            end
            default: begin
               if (mode_ff != MODE_IDLE) begin
                  if (!waiting_ff) begin
                     res_valid   = 1'b1;
                     wait_cnt_in = '0;
                     waiting_in  = 1'b1;
                  end else begin
                     wait_cnt_in = cnt_inc;
                     if (cur_answered_ff || (elapsed &&
                         (mode_ff == MODE_PING || eff_power >= highest_ff))) begin
                        res_valid       = 1'b1;
                        res.event_res   = rnps_pkg::EV_FINISHED;
                        res.node_online = cur_answered_ff;
                        mode_in         = MODE_IDLE;
                        waiting_in      = 1'b0;
                     end else if (elapsed && mode_ff == MODE_SEARCH) begin
                        cur_power_in = eff_power + 1'b1;
                        wr_en        = 1'b1;
                        wr_data      = eff_power + 1'b1;
                        waiting_in   = 1'b0;
                     end
                  end
               end
            end
         endcase
      end
   end

   // response output register with one skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_tready) begin
         if (res_valid) begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = res_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff      <= rnps_pkg::DESIRED_RSSI_RESET;
         lowest_ff       <= rnps_pkg::LOWEST_POWER_RESET;
         highest_ff      <= rnps_pkg::HIGHEST_POWER_RESET;
         wait_ticks_ff   <= rnps_pkg::REPLY_WAIT_RESET;
         offset_ff       <= rnps_pkg::ADDR_OFFSET_RESET;
         mode_ff         <= MODE_IDLE;
         waiting_ff      <= 1'b0;
         cur_node_ff     <= '0;
         wait_cnt_ff     <= '0;
         cur_power_ff    <= '0;
         cur_answered_ff <= 1'b0;
         pending_ff      <= 1'b0;
         rd_valid_ff     <= 1'b0;
         valid_ff        <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               rnps_pkg::CSR_DESIRED_RSSI:  desired_ff    <= csr_wdata[rnps_pkg::RSSI_W-1:0];
               rnps_pkg::CSR_LOWEST_POWER:  lowest_ff     <= csr_wdata[PW-1:0];
               rnps_pkg::CSR_HIGHEST_POWER: highest_ff    <= csr_wdata[PW-1:0];
               rnps_pkg::CSR_REPLY_WAIT:    wait_ticks_ff <= csr_wdata[WW-1:0];
               rnps_pkg::CSR_ADDR_OFFSET:   offset_ff     <= csr_wdata[rnps_pkg::ADDR_W-1:0];
               default: ;
            endcase
         end
         mode_ff         <= mode_in;
         waiting_ff      <= waiting_in;
         cur_node_ff     <= cur_node_in;
         wait_cnt_ff     <= wait_cnt_in;
         cur_power_ff    <= cur_power_in;
         cur_answered_ff <= cur_answered_in;
         pending_ff      <= pending_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         out_valid_ff  <= out_valid_in;
         out_ff        <= out_in;
         skid_valid_ff <= skid_valid_in;
         skid_ff       <= skid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         power_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= power_mem[rd_addr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.event_res;
   assign rsp_tdata  = {3'b0, out_ff.node_online, out_ff.power_level, out_ff.node_address};

endmodule

@@ hdl/rnps_checker.sv @@
// port-level checks for the radio node power search block, bound to the top level
module rnps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [rnps_pkg::OPCODE_W-1:0]      req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rnps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tuser
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // transmit commands never report online
   a_tx_offline: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rnps_pkg::EV_TRANSMIT |-> rsp_tdata[12] == 1'b0)
      else $error("transmit beat with online flag set");

   // start and reply beats produce no response
   a_no_rsp_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid &&
      (req_tuser == rnps_pkg::OP_START_SEARCH || req_tuser == rnps_pkg::OP_START_PING ||
       req_tuser == rnps_pkg::OP_REPLY) |=> !rsp_tvalid)
      else $error("response from a beat that gives none");

endmodule

bind radio_node_power_search_top rnps_checker u_rnps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
